/* rtl/first_fit_constrained_packer_top_assert.svh */
// Assertion macros shared by the packer's checker.
// Depends on nothing; the user supplies clk and rst_n in scope.
`ifndef FIRST_FIT_CONSTRAINED_PACKER_TOP_ASSERT_SVH
`define FIRST_FIT_CONSTRAINED_PACKER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FFCP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define FFCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ffcp_pkg.sv */
// Types and constants of the first-fit constrained packer.
// Used by the top level and by its checker; depends on nothing.
`timescale 1ns / 1ps

package ffcp_pkg;

  localparam int unsigned LIMIT_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_LATENCY_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEMORY_LIMIT  = 1'd1;

  localparam logic [LIMIT_W-1:0] LATENCY_LIMIT_RESET = 16'd50;
  localparam logic [LIMIT_W-1:0] MEMORY_LIMIT_RESET  = 16'd100;

  typedef struct packed {
    logic       start_set;
    logic [9:0] node_id;
    logic [7:0] node_cost;
    logic [7:0] node_latency;
    logic       node_secure;
  } ffcp_in_t;

  typedef struct packed {
    logic [9:0] placed_id;
    logic [5:0] partition_index;
    logic       opened_new;
    logic       table_overflow;
  } ffcp_out_t;

  // One partition table entry as stored in memory.
  typedef struct packed {
    logic               has_secure;
    logic [LIMIT_W-1:0] cost_sum;
    logic [LIMIT_W-1:0] lat_sum;
  } part_entry_t;

endpackage

/* rtl/first_fit_constrained_packer_top.sv */
// Top level of the first-fit constrained packer: sequencer and partition table memory.
// Depends on ffcp_pkg.
`timescale 1ns / 1ps

// Each node transfer is placed into the first open partition whose summed latency
// and summed cost stay within latency_limit and memory_limit after adding the node;
// a secure node may only join a partition that already holds a secure node. When
// no partition fits, a new one is opened for the node, and when the table already
// holds MAX_PARTS partitions the node is dropped with table_overflow set and
// partition_index 0. A node with start_set high empties the table first. The
// partition sums live in a single-port-write, registered-read memory that is
// scanned one entry per cycle from index 0, and the scan stops at the first fit.
// A node against an empty table opens partition 0 without a scan. The result is
// held in an output register, so the next node is taken while a result waits on
// out_stall, and only the final commit of that node waits for the output to free.
// Configuration writes are taken in any cycle and must be made while idle.
// Memory entries need no clearing after reset: only entries below the partition
// count are read, and each was written when its partition was opened.
module first_fit_constrained_packer_top
  import ffcp_pkg::*;
#(
  parameter int unsigned MAX_PARTS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ffcp_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ffcp_out_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0]   cfg_wdata
);

  localparam int unsigned IDX_W = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_PARTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   count_r;
  logic [LIMIT_W-1:0] lat_limit_r;
  logic [LIMIT_W-1:0] mem_limit_r;
  ffcp_in_t           item_r;
  logic [IDX_W-1:0]   eval_idx_r;
  logic [IDX_W-1:0]   res_idx_r;
  logic               res_open_r;
  logic               res_ovf_r;
  logic               wr_en_r;
  part_entry_t        wr_data_r;
  logic               out_valid_r;
  ffcp_out_t          out_data_r;

  part_entry_t        part_mem [MAX_PARTS];
  part_entry_t        rd_data_r;
  logic [IDX_W-1:0]   rd_addr;

  logic [LIMIT_W:0]   new_lat;
  logic [LIMIT_W:0]   new_cost;
  logic               fits;
  logic               last_entry;
  logic               can_open;
  logic               out_free;
  logic               commit;
  logic [IDX_W+5:0]   res_idx_ext;
  part_entry_t        merged_entry;
  part_entry_t        fresh_entry;

  // Entry under test arrives in the cycle after its address; the next address is
  // already on the way, so the scan advances one entry per cycle.
  assign rd_addr = (state_r == ST_SCAN) ? (eval_idx_r + IDX_W'(1)) : '0;

  assign new_lat  = {1'b0, rd_data_r.lat_sum}  + {9'b0, item_r.node_latency};
  assign new_cost = {1'b0, rd_data_r.cost_sum} + {9'b0, item_r.node_cost};
  assign fits     = (new_lat <= {1'b0, lat_limit_r}) &&
                    (new_cost <= {1'b0, mem_limit_r}) &&
                    (!item_r.node_secure || rd_data_r.has_secure);

  assign last_entry = (CNT_W'(eval_idx_r) + CNT_W'(1)) == count_r;
  assign can_open   = count_r < CNT_W'(MAX_PARTS);

  assign merged_entry.has_secure = rd_data_r.has_secure | item_r.node_secure;
  assign merged_entry.cost_sum   = new_cost[LIMIT_W-1:0];
  assign merged_entry.lat_sum    = new_lat[LIMIT_W-1:0];

  assign fresh_entry.has_secure = item_r.node_secure;
  assign fresh_entry.cost_sum   = {8'b0, item_r.node_cost};
  assign fresh_entry.lat_sum    = {8'b0, item_r.node_latency};

  assign out_free    = !out_valid_r || !out_stall;
  assign commit      = (state_r == ST_RESULT) && out_free;
  assign res_idx_ext = {6'b0, res_idx_r};

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Partition table: one write at commit, one registered read per cycle.
  always_ff @(posedge clk) begin
    if (commit && wr_en_r) begin
      part_mem[res_idx_r] <= wr_data_r;
    end
    rd_data_r <= part_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      lat_limit_r <= LATENCY_LIMIT_RESET;
      mem_limit_r <= MEMORY_LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LATENCY_LIMIT: lat_limit_r <= cfg_wdata;
          REG_MEMORY_LIMIT:  mem_limit_r <= cfg_wdata;
          default: ;
        endcase
      end

      // A commit in the same cycle loads the next result instead.
      if (out_valid_r && !out_stall && !commit) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            item_r     <= in_data;
            eval_idx_r <= '0;
            if (in_data.start_set) begin
              count_r <= '0;
            end
            if (in_data.start_set || (count_r == '0)) begin
              // Empty table: the node opens partition 0 without a scan.
              res_idx_r  <= '0;
              res_open_r <= 1'b1;
              res_ovf_r  <= 1'b0;
              wr_en_r    <= 1'b1;
              wr_data_r.has_secure <= in_data.node_secure;
              wr_data_r.cost_sum   <= {8'b0, in_data.node_cost};
              wr_data_r.lat_sum    <= {8'b0, in_data.node_latency};
              state_r    <= ST_RESULT;
            end else begin
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (fits) begin
            res_idx_r  <= eval_idx_r;
            res_open_r <= 1'b0;
            res_ovf_r  <= 1'b0;
            wr_en_r    <= 1'b1;
            wr_data_r  <= merged_entry;
            state_r    <= ST_RESULT;
          end else if (last_entry) begin
            res_open_r <= can_open;
            res_ovf_r  <= !can_open;
            wr_en_r    <= can_open;
            wr_data_r  <= fresh_entry;
            res_idx_r  <= can_open ? count_r[IDX_W-1:0] : '0;
            state_r    <= ST_RESULT;
          end else begin
            eval_idx_r <= eval_idx_r + IDX_W'(1);
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            out_valid_r                <= 1'b1;
            out_data_r.placed_id       <= item_r.node_id;
            out_data_r.partition_index <= res_idx_ext[5:0];
            out_data_r.opened_new      <= res_open_r;
            out_data_r.table_overflow  <= res_ovf_r;
            if (res_open_r) begin
              count_r <= count_r + CNT_W'(1);
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/ffcp_checker.sv */
// Port-level checker for the packer, attached to the top level by bind.
// Depends on ffcp_pkg and first_fit_constrained_packer_top_assert.svh.
`timescale 1ns / 1ps
`include "first_fit_constrained_packer_top_assert.svh"

module ffcp_checker
  import ffcp_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input ffcp_out_t out_data
);

  logic in_xfer;
  logic out_hold;

  assign in_xfer  = in_valid && !in_stall;
  assign out_hold = out_valid && out_stall;

  // A stalled result stays valid and unchanged.
  `FFCP_ASSERT_NEXT(a_out_hold, out_hold, out_valid && $stable(out_data), "result changed while stalled")
  // The block works on one node at a time.
  `FFCP_ASSERT_NEXT(a_busy_after_in, in_xfer, in_stall, "input taken again right after a transfer")
  // A dropped node never reports a new partition.
  `FFCP_ASSERT_NOW(a_ovf_excl, out_valid && out_data.table_overflow, !out_data.opened_new, "overflow with opened_new")
  // A dropped node reports partition 0.
  `FFCP_ASSERT_NOW(a_ovf_idx, out_valid && out_data.table_overflow, out_data.partition_index == 6'd0, "overflow with nonzero index")

endmodule

bind first_fit_constrained_packer_top ffcp_checker u_ffcp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
